### rtl/lte_pkg.sv
// Shared types and constants for the LRU table with expiry.
package lte_pkg;

  localparam int unsigned Slots  = 16;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned CountW = SlotW + 1;

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_INVAL  = 3'd2;
  localparam logic [2:0] OP_PURGE  = 3'd3;
  localparam logic [2:0] OP_FLUSH  = 3'd4;

  localparam int unsigned ST_HIT   = 0;
  localparam int unsigned ST_MISS  = 1;
  localparam int unsigned ST_EVICT = 2;
  localparam int unsigned ST_STORE = 3;

  localparam logic [9:0] SC_OK        = 10'd200;
  localparam logic [9:0] SC_NONAUTH   = 10'd203;
  localparam logic [9:0] SC_NOCONTENT = 10'd204;
  localparam logic [9:0] SC_PARTIAL   = 10'd206;
  localparam logic [9:0] SC_MOVED     = 10'd301;
  localparam logic [9:0] SC_NOTFOUND  = 10'd404;
  localparam logic [9:0] SC_GONE      = 10'd410;

  localparam logic       CFG_SLOT_LIMIT    = 1'b0;
  localparam logic       CFG_BASE_LIFETIME = 1'b1;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOOKUP,
    ACT_INVAL,
    ACT_EVICT,
    ACT_INSERT,
    ACT_FLUSH
  } act_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [63:0]        key_tag;
    logic [31:0]        now;
    logic               method_ok;
    logic [9:0]         status_code;
    logic               no_store;
    logic               private_flag;
    logic               no_cache;
    logic               header_ttl_valid;
    logic signed [31:0] header_ttl;
    logic [30:0]        pinned_ttl;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot;
    logic [9:0]  stored_status;
    logic [32:0] expires_at;
    logic [4:0]  entry_count;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
    logic [31:0] store_count;
  } out_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic purge_step;
    logic out_load;
    act_e act;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       last;
    logic       accept;
    logic       need_evict;
    logic       out_free;
  } sts_t;

  function automatic logic status_ok(logic [9:0] s);
    return s == SC_OK || s == SC_NONAUTH || s == SC_NOCONTENT || s == SC_PARTIAL ||
           s == SC_MOVED || s == SC_NOTFOUND || s == SC_GONE;
  endfunction

endpackage

### rtl/lte_datapath.sv
// Slot table, slot walk, statistics and result register.
module lte_datapath import lte_pkg::*; #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  in_t         in_data_i,
  input  logic [4:0]  slot_limit_i,
  input  logic [30:0] base_lifetime_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output out_t        out_data_o
);

  in_t                 item_q, item_d;
  logic [Slots-1:0]    valid_q, valid_d;
  logic [SlotW-1:0]    rank_q [Slots];
  logic [SlotW-1:0]    rank_d [Slots];
  logic [KEY_BITS-1:0] key_q  [Slots];
  logic [32:0]         exp_q  [Slots];
  logic [9:0]          stat_q [Slots];
  logic [CountW-1:0]   held_q, held_d;
  logic [31:0]         cnt_q [4];
  logic [31:0]         cnt_d [4];
  logic [SlotW-1:0]    idx_q, idx_d;

  logic                found_q, found_d;
  logic [SlotW-1:0]    found_idx_q, found_idx_d, found_rank_q, found_rank_d;
  logic [32:0]         found_exp_q, found_exp_d;
  logic [9:0]          found_stat_q, found_stat_d;
  logic                free_found_q, free_found_d;
  logic [SlotW-1:0]    free_idx_q, free_idx_d;
  logic                lr_found_q, lr_found_d;
  logic [SlotW-1:0]    lr_idx_q, lr_idx_d, lr_rank_q, lr_rank_d;

  logic                res_ok_q, res_ok_d;
  logic [SlotW-1:0]    res_slot_q, res_slot_d;
  logic [9:0]          res_stat_q, res_stat_d;
  logic [32:0]         res_exp_q, res_exp_d;

  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic                wr_en;
  logic [SlotW-1:0]    wr_idx;
  logic [KEY_BITS-1:0] key_in;
  logic [32:0]         now33, new_exp;
  logic [30:0]         ttl;
  logic                force_ttl, accept;
  logic [CountW-1:0]   lim;
  logic [SlotW-1:0]    ins_idx;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [CountW-1:0] held_dec(logic [CountW-1:0] v);
    return (v != '0) ? v - CountW'(1) : v;
  endfunction

  assign key_in    = item_q.key_tag[KEY_BITS-1:0];
  assign now33     = {1'b0, item_q.now};
  assign force_ttl = item_q.pinned_ttl != '0;

  always_comb begin
    if (force_ttl) begin
      ttl = item_q.pinned_ttl;
    end else if (item_q.header_ttl_valid) begin
      ttl = item_q.header_ttl[31] ? '0 : item_q.header_ttl[30:0];
    end else begin
      ttl = base_lifetime_i;
    end
  end

  assign accept = item_q.method_ok && status_ok(item_q.status_code) && !item_q.no_store &&
                  (force_ttl || (!item_q.private_flag && !item_q.no_cache)) && ttl != '0;
  assign new_exp = now33 + {2'b00, ttl};

  always_comb begin
    if (slot_limit_i == '0) begin
      lim = CountW'(1);
    end else if (slot_limit_i > CountW'(Slots)) begin
      lim = CountW'(Slots);
    end else begin
      lim = slot_limit_i;
    end
  end

  assign ins_idx = (found_q && (!free_found_q || found_idx_q < free_idx_q)) ? found_idx_q
                                                                             : free_idx_q;

  assign sts_o.op         = item_q.op;
  assign sts_o.last       = idx_q == SlotW'(Slots - 1);
  assign sts_o.accept     = accept;
  assign sts_o.need_evict = held_q >= lim;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    item_d       = item_q;
    valid_d      = valid_q;
    rank_d       = rank_q;
    held_d       = held_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    found_d      = found_q;
    found_idx_d  = found_idx_q;
    found_rank_d = found_rank_q;
    found_exp_d  = found_exp_q;
    found_stat_d = found_stat_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    lr_found_d   = lr_found_q;
    lr_idx_d     = lr_idx_q;
    lr_rank_d    = lr_rank_q;
    res_ok_d     = res_ok_q;
    res_slot_d   = res_slot_q;
    res_stat_d   = res_stat_q;
    res_exp_d    = res_exp_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    wr_en        = 1'b0;
    wr_idx       = ins_idx;

    if (cmd_i.load) begin
      item_d     = in_data_i;
      res_ok_d   = 1'b0;
      res_slot_d = '0;
      res_stat_d = '0;
      res_exp_d  = '0;
    end

    if (cmd_i.scan_clr) begin
      idx_d        = '0;
      found_d      = 1'b0;
      free_found_d = 1'b0;
      lr_found_d   = 1'b0;
    end

    if (cmd_i.scan_step) begin
      idx_d = idx_q + SlotW'(1);
      if (valid_q[idx_q] && key_q[idx_q] == key_in && !found_q) begin
        found_d      = 1'b1;
        found_idx_d  = idx_q;
        found_rank_d = rank_q[idx_q];
        found_exp_d  = exp_q[idx_q];
        found_stat_d = stat_q[idx_q];
      end
      if (!valid_q[idx_q] && !free_found_q) begin
        free_found_d = 1'b1;
        free_idx_d   = idx_q;
      end
      if (valid_q[idx_q] && (!lr_found_q || rank_q[idx_q] > lr_rank_q)) begin
        lr_found_d = 1'b1;
        lr_idx_d   = idx_q;
        lr_rank_d  = rank_q[idx_q];
      end
    end

    if (cmd_i.purge_step) begin
      idx_d    = idx_q + SlotW'(1);
      res_ok_d = 1'b1;
      if (valid_q[idx_q] && exp_q[idx_q] < now33) begin
        for (int i = 0; i < Slots; i++) begin
          if (valid_q[i] && rank_q[i] > rank_q[idx_q]) rank_d[i] = rank_q[i] - SlotW'(1);
        end
        valid_d[idx_q]  = 1'b0;
        held_d          = held_dec(held_q);
        cnt_d[ST_EVICT] = sat_inc(cnt_q[ST_EVICT]);
      end
    end

    unique case (cmd_i.act)
      ACT_LOOKUP: begin
        if (!found_q) begin
          cnt_d[ST_MISS] = sat_inc(cnt_q[ST_MISS]);
        end else if (now33 > found_exp_q) begin
          for (int i = 0; i < Slots; i++) begin
            if (valid_q[i] && rank_q[i] > found_rank_q) rank_d[i] = rank_q[i] - SlotW'(1);
          end
          valid_d[found_idx_q] = 1'b0;
          held_d               = held_dec(held_q);
          cnt_d[ST_EVICT]      = sat_inc(cnt_q[ST_EVICT]);
          cnt_d[ST_MISS]       = sat_inc(cnt_q[ST_MISS]);
        end else begin
          for (int i = 0; i < Slots; i++) begin
            if (valid_q[i] && rank_q[i] < found_rank_q) rank_d[i] = rank_q[i] + SlotW'(1);
          end
          rank_d[found_idx_q] = '0;
          cnt_d[ST_HIT]       = sat_inc(cnt_q[ST_HIT]);
          res_ok_d            = 1'b1;
          res_slot_d          = found_idx_q;
          res_stat_d          = found_stat_q;
          res_exp_d           = found_exp_q;
        end
      end
      ACT_INVAL: begin
        if (found_q) begin
          for (int i = 0; i < Slots; i++) begin
            if (valid_q[i] && rank_q[i] > found_rank_q) rank_d[i] = rank_q[i] - SlotW'(1);
          end
          valid_d[found_idx_q] = 1'b0;
          held_d               = held_dec(held_q);
          cnt_d[ST_EVICT]      = sat_inc(cnt_q[ST_EVICT]);
          res_ok_d             = 1'b1;
        end
      end
      ACT_EVICT: begin
        if (lr_found_q) begin
          for (int i = 0; i < Slots; i++) begin
            if (valid_q[i] && rank_q[i] > lr_rank_q) rank_d[i] = rank_q[i] - SlotW'(1);
          end
          valid_d[lr_idx_q] = 1'b0;
          held_d            = held_dec(held_q);
          cnt_d[ST_EVICT]   = sat_inc(cnt_q[ST_EVICT]);
        end else begin
          held_d = '0;
        end
      end
      ACT_INSERT: begin
        if (found_q || free_found_q) begin
          for (int i = 0; i < Slots; i++) begin
            if (valid_q[i] && !(found_q && SlotW'(i) == found_idx_q)) begin
              if (found_q && rank_q[i] > found_rank_q) begin
                rank_d[i] = rank_q[i];
              end else begin
                rank_d[i] = rank_q[i] + SlotW'(1);
              end
            end
          end
          if (found_q) valid_d[found_idx_q] = 1'b0;
          valid_d[ins_idx] = 1'b1;
          rank_d[ins_idx]  = '0;
          wr_en            = 1'b1;
          held_d           = found_q ? held_q : held_q + CountW'(1);
          cnt_d[ST_STORE]  = sat_inc(cnt_q[ST_STORE]);
          res_ok_d         = 1'b1;
          res_slot_d       = ins_idx;
          res_stat_d       = item_q.status_code;
          res_exp_d        = new_exp;
        end
      end
      ACT_FLUSH: begin
        valid_d  = '0;
        held_d   = '0;
        cnt_d    = '{default: '0};
        res_ok_d = 1'b1;
      end
      default: begin
      end
    endcase

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_i.out_load) begin
      out_valid_d          = 1'b1;
      out_d.ok             = res_ok_q;
      out_d.slot           = res_slot_q;
      out_d.stored_status  = res_stat_q;
      out_d.expires_at     = res_exp_q;
      out_d.entry_count    = held_q;
      out_d.hit_count      = cnt_q[ST_HIT];
      out_d.miss_count     = cnt_q[ST_MISS];
      out_d.eviction_count = cnt_q[ST_EVICT];
      out_d.store_count    = cnt_q[ST_STORE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      held_q       <= '0;
      cnt_q        <= '{default: '0};
      out_valid_q  <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      lr_found_q   <= 1'b0;
      idx_q        <= '0;
    end else begin
      valid_q      <= valid_d;
      held_q       <= held_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      lr_found_q   <= lr_found_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    rank_q       <= rank_d;
    found_idx_q  <= found_idx_d;
    found_rank_q <= found_rank_d;
    found_exp_q  <= found_exp_d;
    found_stat_q <= found_stat_d;
    free_idx_q   <= free_idx_d;
    lr_idx_q     <= lr_idx_d;
    lr_rank_q    <= lr_rank_d;
    res_ok_q     <= res_ok_d;
    res_slot_q   <= res_slot_d;
    res_stat_q   <= res_stat_d;
    res_exp_q    <= res_exp_d;
    out_q        <= out_d;
    if (wr_en) begin
      key_q[wr_idx]  <= key_in;
      exp_q[wr_idx]  <= new_exp;
      stat_q[wr_idx] <= item_q.status_code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/lte_ctrl.sv
// Operation sequencer: dispatches each transaction and walks the slot table.
module lte_ctrl import lte_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_KEY,
    S_ACT_KEY,
    S_SCAN_LR,
    S_EVICT,
    S_EVICT_CHK,
    S_SCAN_INS,
    S_INSERT,
    S_PURGE,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{act: ACT_NONE, default: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.scan_clr = 1'b1;
        case (sts_i.op)
          OP_LOOKUP, OP_INVAL: state_d = S_SCAN_KEY;
          OP_INSERT: begin
            if (!sts_i.accept) begin
              state_d = S_FINISH;
            end else if (sts_i.need_evict) begin
              state_d = S_SCAN_LR;
            end else begin
              state_d = S_SCAN_INS;
            end
          end
          OP_PURGE: state_d = S_PURGE;
          OP_FLUSH: begin
            cmd_o.act = ACT_FLUSH;
            state_d   = S_FINISH;
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_SCAN_KEY: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.last) state_d = S_ACT_KEY;
      end
      S_ACT_KEY: begin
        cmd_o.act = (sts_i.op == OP_LOOKUP) ? ACT_LOOKUP : ACT_INVAL;
        state_d   = S_FINISH;
      end
      S_SCAN_LR: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.last) state_d = S_EVICT;
      end
      S_EVICT: begin
        cmd_o.act = ACT_EVICT;
        state_d   = S_EVICT_CHK;
      end
      S_EVICT_CHK: begin
        cmd_o.scan_clr = 1'b1;
        state_d        = sts_i.need_evict ? S_SCAN_LR : S_SCAN_INS;
      end
      S_SCAN_INS: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.last) state_d = S_INSERT;
      end
      S_INSERT: begin
        cmd_o.act = ACT_INSERT;
        state_d   = S_FINISH;
      end
      S_PURGE: begin
        cmd_o.purge_step = 1'b1;
        if (sts_i.last) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

### rtl/lru_table_with_expiry.sv
// Top level of the LRU table with expiry: configuration registers and block wiring.
//
// A 16-slot cache tag table with least recent replacement and per-entry expiry.
// One transaction at a time. Lookup, invalidate, purge and accepted inserts walk over
// all 16 slots, one slot a cycle, and an insert walks them once more for each least
// recent eviction it performs. A new transaction is taken while the previous result
// still waits on the output. Configuration: slot limit at byte address 0, base
// lifetime at 4.
module lru_table_with_expiry import lte_pkg::*; #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]  slot_limit_q;
  logic [30:0] base_lifetime_q;
  cmd_t        cmd;
  sts_t        sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit_q    <= 5'd16;
      base_lifetime_q <= 31'd60;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        CFG_SLOT_LIMIT:    slot_limit_q    <= pwdata[4:0];
        CFG_BASE_LIFETIME: base_lifetime_q <= pwdata[30:0];
        default: begin
        end
      endcase
    end
  end

  assign prdata = (paddr[2] == CFG_BASE_LIFETIME) ? {1'b0, base_lifetime_q}
                                                  : {27'd0, slot_limit_q};
  assign pready = 1'b1;

  lte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lte_datapath #(
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_data_i       (in_data_i),
    .slot_limit_i    (slot_limit_q),
    .base_lifetime_i (base_lifetime_q),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_data_o      (out_data_o)
  );

endmodule

### rtl/lte_checker.sv
// Port-level checks for the LRU table with expiry, bound to the top level.
module lte_checker import lte_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= 5'd16)
    else $error("entry count above table size");

  a_status_cacheable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ok && out_data_o.stored_status != '0 |->
      out_data_o.stored_status == SC_OK || out_data_o.stored_status == SC_NONAUTH ||
      out_data_o.stored_status == SC_NOCONTENT || out_data_o.stored_status == SC_PARTIAL ||
      out_data_o.stored_status == SC_MOVED || out_data_o.stored_status == SC_NOTFOUND ||
      out_data_o.stored_status == SC_GONE)
    else $error("uncacheable status reported");

endmodule

bind lru_table_with_expiry lte_checker u_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the LRU table with expiry against a predictor.
`timescale 1ns / 100ps

module testbench;
  import lte_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lru_table_with_expiry u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic        tbl_valid [Slots];
  logic [63:0] tbl_key   [Slots];
  logic [32:0] tbl_exp   [Slots];
  logic [9:0]  tbl_stat  [Slots];
  int unsigned tbl_rank  [Slots];
  int unsigned tbl_held;
  logic [31:0] stats [4];
  logic [4:0]  cfg_max;
  logic [30:0] cfg_ttl;

  in_t    pending_q [$];
  out_t   expected_q [$];
  int     errors;
  int     cycle_cnt;
  int     burst_left;
  int     gap_left;
  int     stall_phase;
  logic   hold_off;
  logic [63:0] keys [8];

  initial clk_i = 1'b0;

  always #10 clk_i = ~clk_i;

  function automatic void bump_stat(int unsigned which);
    if (stats[which] != 32'hFFFF_FFFF) stats[which]++;
  endfunction

  function automatic void drop_slot(int s);
    int unsigned r;
    r = tbl_rank[s];
    tbl_valid[s] = 1'b0;
    for (int i = 0; i < Slots; i++)
      if (tbl_valid[i] && tbl_rank[i] > r) tbl_rank[i]--;
    if (tbl_held > 0) tbl_held--;
  endfunction

  function automatic int find_slot(logic [63:0] k);
    for (int i = 0; i < Slots; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic out_t predict_cache(in_t t);
    out_t        r;
    int          s;
    int          oldest;
    int unsigned lim;
    logic        force_ttl;
    logic        accept;
    logic [32:0] ttl;
    logic        okst;
    r = '0;
    lim = cfg_max;
    if (lim < 1) lim = 1;
    if (lim > Slots) lim = Slots;
    okst = t.status_code inside {SC_OK, SC_NONAUTH, SC_NOCONTENT, SC_PARTIAL,
                                 SC_MOVED, SC_NOTFOUND, SC_GONE};
    case (t.op)
      OP_LOOKUP: begin
        s = find_slot(t.key_tag);
        if (s < 0) begin
          bump_stat(ST_MISS);
        end else if ({1'b0, t.now} > tbl_exp[s]) begin
          drop_slot(s);
          bump_stat(ST_EVICT);
          bump_stat(ST_MISS);
        end else begin
          for (int i = 0; i < Slots; i++)
            if (tbl_valid[i] && tbl_rank[i] < tbl_rank[s]) tbl_rank[i]++;
          tbl_rank[s] = 0;
          bump_stat(ST_HIT);
          r.ok = 1'b1; r.slot = s[3:0];
          r.stored_status = tbl_stat[s]; r.expires_at = tbl_exp[s];
        end
      end
      OP_INSERT: begin
        force_ttl = t.pinned_ttl != 0;
        accept = t.method_ok && okst && !t.no_store &&
                 (force_ttl || (!t.private_flag && !t.no_cache));
        ttl = '0;
        if (force_ttl) ttl = {2'b0, t.pinned_ttl};
        else if (t.header_ttl_valid) ttl = t.header_ttl[31] ? '0 : {1'b0, t.header_ttl};
        else ttl = {2'b0, cfg_ttl};
        if (ttl == 0) accept = 1'b0;
        if (accept) begin
          while (tbl_held >= lim) begin
            oldest = -1;
            for (int i = 0; i < Slots; i++)
              if (tbl_valid[i] && (oldest < 0 || tbl_rank[i] > tbl_rank[oldest])) oldest = i;
            if (oldest < 0) begin
              tbl_held = 0;
              break;
            end
            drop_slot(oldest);
            bump_stat(ST_EVICT);
          end
          s = find_slot(t.key_tag);
          if (s >= 0) drop_slot(s);
          s = -1;
          for (int i = 0; i < Slots; i++)
            if (!tbl_valid[i] && s < 0) s = i;
          if (s >= 0) begin
            for (int i = 0; i < Slots; i++)
              if (tbl_valid[i]) tbl_rank[i]++;
            tbl_valid[s] = 1'b1;
            tbl_key[s] = t.key_tag;
            tbl_exp[s] = {1'b0, t.now} + ttl;
            tbl_stat[s] = t.status_code;
            tbl_rank[s] = 0;
            tbl_held++;
            bump_stat(ST_STORE);
            r.ok = 1'b1; r.slot = s[3:0];
            r.stored_status = t.status_code; r.expires_at = tbl_exp[s];
          end
        end
      end
      OP_INVAL: begin
        s = find_slot(t.key_tag);
        if (s >= 0) begin
          drop_slot(s);
          bump_stat(ST_EVICT);
          r.ok = 1'b1;
        end
      end
      OP_PURGE: begin
        for (int i = 0; i < Slots; i++)
          if (tbl_valid[i] && tbl_exp[i] < {1'b0, t.now}) begin
            drop_slot(i);
            bump_stat(ST_EVICT);
          end
        r.ok = 1'b1;
      end
      OP_FLUSH: begin
        for (int i = 0; i < Slots; i++) tbl_valid[i] = 1'b0;
        for (int i = 0; i < 4; i++) stats[i] = '0;
        tbl_held = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.entry_count = tbl_held[4:0];
    r.hit_count = stats[ST_HIT];
    r.miss_count = stats[ST_MISS];
    r.eviction_count = stats[ST_EVICT];
    r.store_count = stats[ST_STORE];
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) expected_q.push_back(predict_cache(in_data_i));
      if (hold_off || pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        burst_left <= $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
      end else begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_q.pop_front();
        burst_left <= burst_left - 1;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_phase <= 0;
      cycle_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      stall_phase <= stall_phase + 1;
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_o);
          errors++;
        end else begin
          out_t e;
          e = expected_q.pop_front();
          if (e !== out_data_o) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_data_o);
            errors++;
          end
        end
      end
      if (stall_phase[9:8] == 2'd0) out_stall_i <= 1'b0;
      else out_stall_i <= (stall_phase[3:0] < stall_phase[7:6] * 3) || ($urandom_range(0, 7) == 0);
      if (cycle_cnt > 2_000_000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) cfg_max = val[4:0];
    else cfg_ttl = val[30:0];
  endtask

  task automatic drain_all();
    while (pending_q.size() != 0) @(posedge clk_i);
    hold_off = 1'b1;
    while (in_valid_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic in_t make_txn(logic [2:0] op, logic [63:0] k, logic [31:0] t);
    in_t x;
    x = '0;
    x.op = op; x.key_tag = k; x.now = t;
    x.method_ok = 1'b1; x.status_code = SC_OK;
    return x;
  endfunction

  task automatic queue_random(int n, logic [31:0] t0, int key_span);
    in_t x;
    logic [9:0] codes [7];
    logic [31:0] t;
    codes = '{SC_OK, SC_NONAUTH, SC_NOCONTENT, SC_PARTIAL, SC_MOVED, SC_NOTFOUND, SC_GONE};
    t = t0;
    for (int i = 0; i < n; i++) begin
      t = t + $urandom_range(0, 20);
      x.op = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(4, 7)) :
             3'($urandom_range(0, 99) < 45 ? OP_LOOKUP : $urandom_range(1, 3));
      x.key_tag = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom} :
                  keys[$urandom_range(0, key_span - 1)];
      x.now = ($urandom_range(0, 40) == 0) ? $urandom : t;
      x.method_ok = $urandom_range(0, 9) != 0;
      x.status_code = ($urandom_range(0, 7) == 0) ? 10'($urandom) : codes[$urandom_range(0, 6)];
      x.no_store = $urandom_range(0, 9) == 0;
      x.private_flag = $urandom_range(0, 7) == 0;
      x.no_cache = $urandom_range(0, 7) == 0;
      x.header_ttl_valid = 1'($urandom_range(0, 1));
      x.header_ttl = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 200);
      x.pinned_ttl = ($urandom_range(0, 3) == 0) ?
                     (($urandom_range(0, 5) == 0) ? 31'($urandom) :
                                                    31'($urandom_range(1, 300))) : '0;
      pending_q.push_back(x);
    end
  endtask

  initial begin
    in_t x;
    errors = 0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    for (int i = 0; i < Slots; i++) begin
      tbl_valid[i] = 1'b0; tbl_rank[i] = 0; tbl_key[i] = '0; tbl_exp[i] = '0; tbl_stat[i] = '0;
    end
    for (int i = 0; i < 4; i++) stats[i] = '0;
    tbl_held = 0;
    cfg_max = 5'd16;
    cfg_ttl = 31'd60;
    keys[0] = '0;
    keys[1] = '1;
    for (int i = 2; i < 8; i++) keys[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    pending_q.push_back(make_txn(OP_LOOKUP, keys[0], 32'd10));
    pending_q.push_back(make_txn(OP_INSERT, keys[0], 32'd10));
    pending_q.push_back(make_txn(OP_LOOKUP, keys[0], 32'd70));
    pending_q.push_back(make_txn(OP_LOOKUP, keys[0], 32'd71));
    x = make_txn(OP_INSERT, keys[1], 32'hFFFF_FFFF);
    x.pinned_ttl = 31'h7FFF_FFFF; x.private_flag = 1'b1; x.no_cache = 1'b1;
    x.status_code = SC_GONE;
    pending_q.push_back(x);
    pending_q.push_back(make_txn(OP_LOOKUP, keys[1], 32'hFFFF_FFFF));
    x = make_txn(OP_INSERT, keys[2], 32'd5); x.header_ttl_valid = 1'b1;
    x.header_ttl = 32'h8000_0000;
    pending_q.push_back(x);
    x.header_ttl = 32'h7FFF_FFFF; x.status_code = SC_MOVED;
    pending_q.push_back(x);
    x.header_ttl = 0;
    pending_q.push_back(x);
    x = make_txn(OP_INSERT, keys[3], 32'd5); x.no_store = 1'b1; x.pinned_ttl = 31'd9;
    pending_q.push_back(x);
    x = make_txn(OP_INSERT, keys[3], 32'd5); x.private_flag = 1'b1;
    pending_q.push_back(x);
    x = make_txn(OP_INSERT, keys[3], 32'd5); x.status_code = 10'd1023;
    pending_q.push_back(x);
    x = make_txn(OP_INSERT, keys[3], 32'd5); x.method_ok = 1'b0;
    pending_q.push_back(x);
    x = make_txn(OP_INSERT, keys[3], 32'd5); x.status_code = SC_NOCONTENT;
    pending_q.push_back(x);
    pending_q.push_back(make_txn(OP_INSERT, keys[3], 32'd6));
    pending_q.push_back(make_txn(OP_INVAL, keys[3], 32'd6));
    pending_q.push_back(make_txn(OP_INVAL, keys[3], 32'd6));
    pending_q.push_back(make_txn(OP_PURGE, keys[0], 32'd200));
    pending_q.push_back(make_txn(3'd5, keys[0], 32'd0));
    pending_q.push_back(make_txn(3'd7, keys[0], 32'd0));
    pending_q.push_back(make_txn(OP_FLUSH, keys[0], 32'd0));
    drain_all();
    hold_off = 1'b0;

    write_reg(3'd0, 32'd2);
    write_reg(3'd4, 32'd0);
    queue_random(120, 32'd0, 8);
    drain_all();
    hold_off = 1'b0;

    write_reg(3'd0, 32'd0);
    write_reg(3'd4, 32'h7FFF_FFFF);
    queue_random(80, 32'h8000_0000, 4);
    drain_all();
    hold_off = 1'b0;

    write_reg(3'd0, 32'd31);
    write_reg(3'd4, 32'd40);
    for (int i = 0; i < 8; i++) keys[i] = {$urandom, $urandom};
    keys[0] = '1;
    queue_random(250, 32'd1000, 8);
    drain_all();
    hold_off = 1'b0;

    write_reg(3'd0, 32'd3);
    write_reg(3'd4, 32'd100);
    queue_random(150, 32'd5000, 8);
    drain_all();
    hold_off = 1'b0;

    write_reg(3'd0, 32'd16);
    write_reg(3'd4, 32'd1);
    queue_random(150, 32'hFFFF_0000, 8);
    drain_all();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### lru_table_with_expiry.f
rtl/lte_pkg.sv
rtl/lte_datapath.sv
rtl/lte_ctrl.sv
rtl/lru_table_with_expiry.sv
rtl/lte_checker.sv
tb/testbench.sv
